@@ rtl/iba_pkg.sv @@
// Package for the indexed block allocator: sizes, status codes and the
// controller/datapath command and status structs. No dependencies.
package iba_pkg;

	localparam int NUM_BLOCKS_DEF  = 64;
	localparam int BLOCK_BYTES_DEF = 64;
	localparam int NUM_FILES_DEF   = 16;
	localparam int INDEX_CAP_DEF   = 8;

	localparam int STATUS_W = 3;
	localparam int ID_W     = 4;
	localparam int IB_W     = 6;
	localparam int CNT_W    = 4;
	localparam int FREE_W   = 7;
	localparam int NAME_W   = 64;
	localparam int SIZE_W   = 16;

	localparam logic [STATUS_W-1:0] ST_CREATED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DELETED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // latch request, clear scan
		logic scan_step;  // compare current slot, advance
		logic check;      // register create checks, load slot fields
		logic pop_ib;     // pop index block
		logic pop_data;   // pop data block, write index entry
		logic rd_entry;   // issue index-entry read
		logic push_data;  // push read entry
		logic push_ib;    // push index block
		logic commit;     // update slot table, id stack, count
		logic fail;       // result is failure with status from check
	} iba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;  // scan finished (hit or end)
		logic hit;        // slot found
		logic ok;         // create checks passed
		logic loop_done;  // data-block loop counter at count
		logic is_delete;
	} iba_sts_t;

endpackage

@@ rtl/indexed_block_allocator_top.sv @@
// Top level of the indexed block allocator: stream ports, output register.
// Depends on iba_pkg, iba_ctrl, iba_dp (and iba_ram below it).
//
// One request word in, one result word out. A create takes the index block
// and then ceil(size/BLOCK_BYTES) data blocks off a LIFO free-block stack,
// records them in the index memory, pops a file id and fills the first free
// slot. A delete finds the first slot with the same name, pushes its data
// blocks back in entry order, then the index block, and returns the id.
// A request first scans the slots, up to the found slot or past the last
// one, then checks; a create pops the index block and then one data block
// per step, while a delete handles each of its blocks with a read, a wait
// on the registered index-memory read port, a push and a decision, then
// pushes the index block. A failed request goes straight to the result.
// One request is in work at a time: a new word is taken whenever the
// controller is idle, which it is again once the result is loaded; a result
// that finds the output word still held waits for it to drain. Block size
// is a package constant and must be a power of two. No clearing pass after
// reset: stack entries below the lowest top reached since reset still read
// as their reset contents.
module indexed_block_allocator_top #(
	parameter int NUM_BLOCKS  = iba_pkg::NUM_BLOCKS_DEF,
	parameter int NUM_FILES   = iba_pkg::NUM_FILES_DEF,
	parameter int INDEX_CAP   = iba_pkg::INDEX_CAP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,  // req_type[0]
	input  logic [79:0] s_tdata,  // file_name[63:0], req_size[79:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // status[2:0], file_id[6:3], idx_blk[12:7],
	                              // blk_count[16:13], free_blocks[23:17]
);
	iba_pkg::iba_cmd_t cmd;
	iba_pkg::iba_sts_t sts;
	logic idle, result, out_busy;
	logic [iba_pkg::STATUS_W-1:0] r_st;
	logic [iba_pkg::ID_W-1:0]     r_id;
	logic [iba_pkg::IB_W-1:0]     r_ib;
	logic [iba_pkg::CNT_W-1:0]    r_cnt;
	logic [iba_pkg::FREE_W-1:0]   r_free;
	logic out_q;

	// result register: the datapath holds the word, out_q marks it valid
	assign out_busy = out_q && !m_tready;
	assign s_tready = idle;
	assign m_tvalid = out_q;
	assign m_tdata  = {r_free, r_cnt, r_ib, r_id, r_st};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_q <= 1'b0;
		else if (result) out_q <= 1'b1;
		else if (m_tready) out_q <= 1'b0;
	end

	iba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.out_busy(out_busy), .sts(sts), .cmd(cmd), .idle(idle), .result(result)
	);

	iba_dp #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.NUM_FILES(NUM_FILES), .INDEX_CAP(INDEX_CAP)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(s_tuser), .file_name(s_tdata[63:0]), .req_size(s_tdata[79:64]),
		.res_status(r_st), .res_file_id(r_id), .res_idx_blk(r_ib),
		.res_count(r_cnt), .res_free(r_free)
	);
endmodule

@@ rtl/iba_ram.sv @@
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module iba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/iba_ctrl.sv @@
// Controller state machine for the indexed block allocator.
// Depends on iba_pkg.
module iba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_busy,
	input  iba_pkg::iba_sts_t sts,
	output iba_pkg::iba_cmd_t cmd,
	output logic              idle,
	output logic              result
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_DEC   = 4'd3;
	localparam logic [3:0] S_POPIB = 4'd4;
	localparam logic [3:0] S_POPD  = 4'd5;
	localparam logic [3:0] S_RD    = 4'd6;
	localparam logic [3:0] S_WAIT  = 4'd7;
	localparam logic [3:0] S_PUSHD = 4'd8;
	localparam logic [3:0] S_PUSHI = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;
	localparam logic [3:0] S_FAIL  = 4'd11;

	logic [3:0] state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		result = 1'b0;
		idle = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				if (sts.is_delete) begin
					state_d = sts.hit ? (sts.loop_done ? S_PUSHI : S_RD) : S_FAIL;
				end else begin
					state_d = sts.ok ? S_POPIB : S_FAIL;
				end
			end
			S_POPIB: begin
				cmd.pop_ib = 1'b1;
				state_d = S_POPD;
			end
			S_POPD: begin
				if (sts.loop_done) state_d = S_DONE;
				else cmd.pop_data = 1'b1;
			end
			S_RD: begin
				cmd.rd_entry = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: state_d = S_PUSHD;
			S_PUSHD: begin
				cmd.push_data = 1'b1;
				state_d = S_DEC;
			end
			S_PUSHI: begin
				cmd.push_ib = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_busy) begin
					cmd.commit = 1'b1;
					result = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FAIL: begin
				if (!out_busy) begin
					cmd.fail = 1'b1;
					result = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

@@ rtl/iba_dp.sv @@
// Datapath for the indexed block allocator: stacks, slot table, index RAM.
// Depends on iba_pkg and iba_ram.
module iba_dp #(
	parameter int NUM_BLOCKS  = iba_pkg::NUM_BLOCKS_DEF,
	parameter int NUM_FILES   = iba_pkg::NUM_FILES_DEF,
	parameter int INDEX_CAP   = iba_pkg::INDEX_CAP_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iba_pkg::iba_cmd_t             cmd,
	output iba_pkg::iba_sts_t             sts,
	input  logic                          req_type,
	input  logic [iba_pkg::NAME_W-1:0]    file_name,
	input  logic [iba_pkg::SIZE_W-1:0]    req_size,
	output logic [iba_pkg::STATUS_W-1:0]  res_status,
	output logic [iba_pkg::ID_W-1:0]      res_file_id,
	output logic [iba_pkg::IB_W-1:0]      res_idx_blk,
	output logic [iba_pkg::CNT_W-1:0]     res_count,
	output logic [iba_pkg::FREE_W-1:0]    res_free
);
	localparam int BW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int BTW = $clog2(NUM_BLOCKS + 1);
	localparam int FW  = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
	localparam int FTW = $clog2(NUM_FILES + 1);
	localparam int CW  = $clog2(INDEX_CAP + 1);
	localparam int EW  = (INDEX_CAP > 1) ? $clog2(INDEX_CAP) : 1;
	// block size is a package constant, a power of two: ceil is add and shift
	localparam int SHW = $clog2(iba_pkg::BLOCK_BYTES_DEF);
	localparam int QW  = iba_pkg::SIZE_W + 1;
	localparam int AW  = $clog2(NUM_BLOCKS * INDEX_CAP);
	localparam int OW  = iba_pkg::STATUS_W;

	// free block stack in RAM; id stack and slot table in flip-flops
	logic [BTW-1:0] blk_top_q;
	logic [BTW-1:0] blk_top_nx;
	logic [BTW-1:0] min_top_q;
	logic [FW-1:0]  id_stk_q [NUM_FILES];
	logic [FTW-1:0] id_top_q;
	logic [FTW-1:0] in_use_q;
	logic [NUM_FILES-1:0] valid_q;
	logic [iba_pkg::NAME_W-1:0] sname_q [NUM_FILES];
	logic [FW-1:0]  sid_q [NUM_FILES];
	logic [BW-1:0]  sib_q [NUM_FILES];
	logic [CW-1:0]  scnt_q [NUM_FILES];

	logic                       del_q;
	logic [iba_pkg::NAME_W-1:0] name_q;
	logic [QW-1:0]              need_q;
	logic [FTW-1:0]             scan_q;
	logic                       hit_q;
	logic [FW-1:0]              slot_q;
	logic                       ok_q;
	logic [OW-1:0]              fst_q;
	logic [BW-1:0]              ib_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              i_q;
	logic [FW-1:0]              id_q;

	logic [FW-1:0] scan_idx;
	logic          scan_match;
	logic          scan_end;
	logic [BW-1:0] top_blk;
	logic [BW-1:0] ent_rd;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] i_idx;
	logic          stk_we;
	logic [BW-1:0] stk_waddr;
	logic [BW-1:0] stk_wdata;
	logic [BW-1:0] stk_raddr;
	logic [BW-1:0] stk_rd;

	assign scan_idx = scan_q[FW-1:0];
	assign scan_end = (scan_q == FTW'(NUM_FILES));
	assign scan_match = del_q ? (valid_q[scan_idx] && sname_q[scan_idx] == name_q)
	                          : !valid_q[scan_idx];
	assign i_idx = i_q[EW-1:0];
	assign waddr = AW'(ib_q) * AW'(INDEX_CAP) + AW'(i_idx);
	assign raddr = waddr;

	// stack top: pops and pushes never share a cycle
	assign stk_we    = (cmd.push_data || cmd.push_ib) && (blk_top_q < BTW'(NUM_BLOCKS));
	assign stk_waddr = BW'(blk_top_q);
	assign stk_wdata = cmd.push_ib ? ib_q : ent_rd;

	always_comb begin
		blk_top_nx = blk_top_q;
		if (cmd.pop_ib || cmd.pop_data) blk_top_nx = blk_top_q - BTW'(1);
		else if (stk_we) blk_top_nx = blk_top_q + BTW'(1);
	end

	// read ahead at the next top so the top entry is ready every cycle
	assign stk_raddr = BW'(blk_top_nx - BTW'(1));
	// entries below the low-water mark were never written: reset contents
	assign top_blk = (blk_top_q == min_top_q) ? BW'(BTW'(NUM_BLOCKS) - blk_top_q) : stk_rd;

	iba_ram #(.WIDTH(BW), .DEPTH(NUM_BLOCKS)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rd)
	);

	iba_ram #(.WIDTH(BW), .DEPTH(NUM_BLOCKS * INDEX_CAP)) u_index (
		.clk(clk), .we(cmd.pop_data), .waddr(waddr), .wdata(top_blk),
		.raddr(raddr), .rdata(ent_rd)
	);

	assign sts.scan_done = hit_q || scan_end || (!scan_end && scan_match);
	assign sts.hit = hit_q;
	assign sts.ok = ok_q;
	assign sts.loop_done = (i_q == cnt_q);
	assign sts.is_delete = del_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			del_q  <= req_type;
			name_q <= file_name;
			need_q <= (QW'(req_size) + QW'(iba_pkg::BLOCK_BYTES_DEF - 1)) >> SHW;
		end
		if (cmd.scan_step && !hit_q && !scan_end && scan_match) slot_q <= scan_idx;
		if (cmd.check) begin
			ib_q <= sib_q[slot_q];
			id_q <= sid_q[slot_q];
			if (del_q) begin
				cnt_q <= (scnt_q[slot_q] > CW'(INDEX_CAP)) ? CW'(INDEX_CAP) : scnt_q[slot_q];
				fst_q <= iba_pkg::ST_NOT_FOUND;
				ok_q  <= hit_q;
			end else begin
				cnt_q <= CW'(need_q);
				if (in_use_q >= FTW'(NUM_FILES) || !hit_q || id_top_q == '0) begin
					fst_q <= iba_pkg::ST_TABLE_FULL; ok_q <= 1'b0;
				end else if (need_q > QW'(INDEX_CAP)) begin
					fst_q <= iba_pkg::ST_TOO_LARGE; ok_q <= 1'b0;
				end else if (QW'(blk_top_q) < need_q + QW'(1)) begin
					fst_q <= iba_pkg::ST_NO_SPACE; ok_q <= 1'b0;
				end else ok_q <= 1'b1;
			end
		end
		if (cmd.pop_ib) ib_q <= top_blk;
		if (cmd.commit) begin
			res_status      <= del_q ? iba_pkg::ST_DELETED : iba_pkg::ST_CREATED;
			res_file_id     <= del_q ? iba_pkg::ID_W'(id_q) : iba_pkg::ID_W'(id_stk_q[FW'(id_top_q - FTW'(1))]);
			res_idx_blk     <= iba_pkg::IB_W'(ib_q);
			res_count       <= iba_pkg::CNT_W'(cnt_q);
			res_free        <= iba_pkg::FREE_W'(blk_top_q);
			if (!del_q) begin
				sname_q[slot_q] <= name_q;
				sid_q[slot_q]   <= id_stk_q[FW'(id_top_q - FTW'(1))];
				sib_q[slot_q]   <= ib_q;
				scnt_q[slot_q]  <= cnt_q;
			end
		end
		if (cmd.fail) begin
			res_status      <= fst_q;
			res_file_id     <= '0;
			res_idx_blk     <= '0;
			res_count       <= '0;
			res_free        <= iba_pkg::FREE_W'(blk_top_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_FILES; k++) id_stk_q[k] <= FW'(k);
			blk_top_q <= BTW'(NUM_BLOCKS);
			min_top_q <= BTW'(NUM_BLOCKS);
			id_top_q  <= FTW'(NUM_FILES);
			in_use_q  <= '0;
			valid_q   <= '0;
			scan_q    <= '0;
			hit_q     <= 1'b0;
			i_q       <= '0;
		end else begin
			if (cmd.load) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
				i_q    <= '0;
			end
			if (cmd.scan_step && !hit_q && !scan_end) begin
				if (scan_match) hit_q <= 1'b1;
				else scan_q <= scan_q + FTW'(1);
			end
			blk_top_q <= blk_top_nx;
			if (blk_top_nx < min_top_q) min_top_q <= blk_top_nx;
			if (cmd.pop_data || cmd.push_data) i_q <= i_q + CW'(1);
			if (cmd.commit) begin
				if (del_q) begin
					valid_q[slot_q] <= 1'b0;
					if (in_use_q != '0) in_use_q <= in_use_q - FTW'(1);
					if (id_top_q < FTW'(NUM_FILES)) begin
						id_stk_q[FW'(id_top_q)] <= id_q;
						id_top_q <= id_top_q + FTW'(1);
					end
				end else begin
					valid_q[slot_q] <= 1'b1;
					in_use_q <= in_use_q + FTW'(1);
					id_top_q <= id_top_q - FTW'(1);
				end
			end
		end
	end
endmodule

@@ dv/indexed_block_allocator_top_tb.sv @@
// Testbench for indexed_block_allocator_top: directed and random create/delete
// requests, checked word by word against an in-bench allocator predictor.
// Depends on iba_pkg and the RTL of the allocator.
module indexed_block_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBLK = iba_pkg::NUM_BLOCKS_DEF;
	localparam int BBYTES = iba_pkg::BLOCK_BYTES_DEF;
	localparam int NFILE = iba_pkg::NUM_FILES_DEF;
	localparam int ICAP = iba_pkg::INDEX_CAP_DEF;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic REQ_CREATE = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	typedef struct packed {
		logic [iba_pkg::FREE_W-1:0]   free_blocks;
		logic [iba_pkg::CNT_W-1:0]    blk_count;
		logic [iba_pkg::IB_W-1:0]     idx_blk;
		logic [iba_pkg::ID_W-1:0]     file_id;
		logic [iba_pkg::STATUS_W-1:0] status;
	} alloc_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic s_tuser;
	logic [79:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;

	indexed_block_allocator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state: mirror of the allocator tables
	logic [iba_pkg::IB_W-1:0]   blk_stack [NBLK];
	int                         blk_top;
	logic [iba_pkg::ID_W-1:0]   id_stack [NFILE];
	int                         id_top;
	logic                       slot_used [NFILE];
	logic [iba_pkg::NAME_W-1:0] slot_tag [NFILE];
	logic [iba_pkg::ID_W-1:0]   slot_id [NFILE];
	logic [iba_pkg::IB_W-1:0]   slot_ib [NFILE];
	logic [iba_pkg::CNT_W-1:0]  slot_cnt [NFILE];
	logic [iba_pkg::IB_W-1:0]   idx_mem [NBLK*ICAP];
	int                         open_files;

	alloc_result_t expected_results[$];
	logic [iba_pkg::NAME_W-1:0] live_names[$];
	int  fail_count = 0;
	int  idle_cycles = 0;
	bit  allow_stall = 1;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic reset_model();
		for (int i = 0; i < NBLK; i++) blk_stack[i] = iba_pkg::IB_W'(NBLK - 1 - i);
		blk_top = NBLK;
		for (int i = 0; i < NFILE; i++) begin
			id_stack[i] = iba_pkg::ID_W'(i);
			slot_used[i] = 0;
		end
		id_top = NFILE;
		open_files = 0;
	endtask

	// Works out the result of one request and updates the mirrored tables.
	function automatic alloc_result_t allocate_or_free(logic kind,
			logic [iba_pkg::NAME_W-1:0] tag, logic [iba_pkg::SIZE_W-1:0] bytes);
		alloc_result_t r;
		int slot;
		int cnt;
		logic [iba_pkg::IB_W-1:0] ib;
		r = '0;
		slot = 0;
		if (kind == REQ_CREATE) begin
			while (slot < NFILE && slot_used[slot]) slot++;
			cnt = (int'(bytes) + BBYTES - 1) / BBYTES;
			if (open_files >= NFILE || slot >= NFILE || id_top == 0)
				r.status = iba_pkg::ST_TABLE_FULL;
			else if (cnt > ICAP)
				r.status = iba_pkg::ST_TOO_LARGE;
			else if (blk_top < cnt + 1)
				r.status = iba_pkg::ST_NO_SPACE;
			else begin
				blk_top--;
				ib = blk_stack[blk_top];
				for (int i = 0; i < cnt; i++) begin
					blk_top--;
					idx_mem[ib*ICAP + i] = blk_stack[blk_top];
				end
				id_top--;
				slot_used[slot] = 1;
				slot_tag[slot] = tag;
				slot_id[slot] = id_stack[id_top];
				slot_ib[slot] = ib;
				slot_cnt[slot] = iba_pkg::CNT_W'(cnt);
				open_files++;
				r.status = iba_pkg::ST_CREATED;
				r.file_id = id_stack[id_top];
				r.idx_blk = ib;
				r.blk_count = iba_pkg::CNT_W'(cnt);
			end
		end else begin
			while (slot < NFILE && !(slot_used[slot] && slot_tag[slot] == tag)) slot++;
			if (slot >= NFILE)
				r.status = iba_pkg::ST_NOT_FOUND;
			else begin
				ib = slot_ib[slot];
				for (int i = 0; i < int'(slot_cnt[slot]); i++)
					if (blk_top < NBLK) blk_stack[blk_top++] = idx_mem[ib*ICAP + i];
				if (blk_top < NBLK) blk_stack[blk_top++] = ib;
				if (id_top < NFILE) id_stack[id_top++] = slot_id[slot];
				slot_used[slot] = 0;
				if (open_files > 0) open_files--;
				r.status = iba_pkg::ST_DELETED;
				r.file_id = slot_id[slot];
				r.idx_blk = ib;
				r.blk_count = slot_cnt[slot];
			end
		end
		r.free_blocks = iba_pkg::FREE_W'(blk_top);
		return r;
	endfunction

	// Sends one request word after a random gap; prediction at acceptance.
	// tvalid stays up after acceptance until the next gap or a drain.
	task automatic send_request(logic kind, logic [iba_pkg::NAME_W-1:0] tag,
			logic [iba_pkg::SIZE_W-1:0] bytes);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {bytes, tag};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(allocate_or_free(kind, tag, bytes));
	endtask

	// result checker
	always @(posedge clk) begin
		alloc_result_t got, exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = alloc_result_t'(m_tdata);
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: %h", m_tdata);
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got.status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, got.status);
					fail_count++;
				end
				if (got.file_id !== exp_r.file_id) begin
					$error("file_id exp %0d got %0d", exp_r.file_id, got.file_id);
					fail_count++;
				end
				if (got.idx_blk !== exp_r.idx_blk) begin
					$error("idx_blk exp %0d got %0d", exp_r.idx_blk, got.idx_blk);
					fail_count++;
				end
				if (got.blk_count !== exp_r.blk_count) begin
					$error("blk_count exp %0d got %0d", exp_r.blk_count,
						got.blk_count);
					fail_count++;
				end
				if (got.free_blocks !== exp_r.free_blocks) begin
					$error("free_blocks exp %0d got %0d", exp_r.free_blocks, got.free_blocks);
					fail_count++;
				end
			end
		end
	end

	// receiver stall: before each word m_tready may drop for a random gap, none while allow_stall is clear
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = allow_stall ? $urandom_range(0, 4) : 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// watchdog: cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	function automatic logic [iba_pkg::NAME_W-1:0] fresh_tag();
		return {$urandom(), $urandom()};
	endfunction

	// Fields at their extremes, every status but table full, zero size, duplicate names.
	task automatic test_directed();
		logic [iba_pkg::NAME_W-1:0] all1, dup;
		all1 = '1;
		dup = 64'h0123_4567_89ab_cdef;
		send_request(REQ_DELETE, '0, '1);               // not found on empty table
		send_request(REQ_CREATE, '0, '0);               // zero size
		send_request(REQ_CREATE, all1, 16'd512);         // exactly INDEX_CAP blocks
		send_request(REQ_CREATE, dup, 16'd513);          // too large
		send_request(REQ_CREATE, dup, '1);               // too large, max size
		send_request(REQ_CREATE, dup, 16'd1);
		send_request(REQ_CREATE, dup, 16'd64);           // duplicate name
		send_request(REQ_DELETE, dup, '0);               // first match
		send_request(REQ_DELETE, all1, 16'hffff);
		send_request(REQ_DELETE, '0, '0);
		send_request(REQ_DELETE, dup, '0);
		send_request(REQ_DELETE, dup, '0);               // now not found
		// exhaust blocks: 7 files x 9 blocks = 63, then no space
		for (int i = 0; i < 7; i++) send_request(REQ_CREATE, 64'(i + 100), 16'd500);
		send_request(REQ_CREATE, 64'd200, 16'd1);        // needs 2, only 1 free
		send_request(REQ_CREATE, 64'd201, 16'd0);        // takes last block
		for (int i = 0; i < 7; i++) send_request(REQ_DELETE, 64'(i + 100), '0);
		send_request(REQ_DELETE, 64'd201, '0);
	endtask

	// Fill the table to hit table full, then empty it.
	task automatic test_table_full();
		for (int i = 0; i < NFILE + 2; i++) send_request(REQ_CREATE, 64'(i), 16'($urandom_range(0, 64)));
		wait_drained();                                  // sender holds until all results are in
		for (int i = NFILE + 1; i >= 0; i--) send_request(REQ_DELETE, 64'(i), '0);
	endtask

	// Mostly valid create/delete of live names; some noise.
	task automatic test_random(int count);
		logic [iba_pkg::NAME_W-1:0] tag;
		logic [iba_pkg::SIZE_W-1:0] bytes;
		int pick, k;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2) allow_stall = 0;
			if (n == count / 2 + 100) allow_stall = 1;
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				tag = ($urandom_range(0, 3) == 0 && live_names.size() != 0) ?
					live_names[$urandom_range(0, live_names.size() - 1)] : fresh_tag();
				case ($urandom_range(0, 9))
					0: bytes = 16'($urandom());
					1: bytes = '0;
					2: bytes = 16'($urandom_range(1, 5) * BBYTES);
					default: bytes = 16'($urandom_range(1, 300));
				endcase
				if (open_files < NFILE && blk_top >= (int'(bytes) + BBYTES - 1) / BBYTES + 1
						&& (int'(bytes) + BBYTES - 1) / BBYTES <= ICAP)
					live_names.push_back(tag);
				send_request(REQ_CREATE, tag, bytes);
			end else if (pick < 90 && live_names.size() != 0) begin
				k = $urandom_range(0, live_names.size() - 1);
				tag = live_names[k];
				live_names.delete(k);
				send_request(REQ_DELETE, tag, 16'($urandom()));
			end else
				send_request(REQ_DELETE, fresh_tag(), 16'($urandom()));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		reset_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_random(1100);
		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
